>>> src/assert_macros.svh
// Assertion macros shared by the tilt drive RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high
`define ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_CLK_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

>>> src/tdd_pkg.sv
// Types, constants and the arctangent table for the tilt drive block
`default_nettype none

package tdd_pkg;

  localparam int IN_W  = 16;  // raw sample width
  localparam int NEG_W = 17;  // negated sample width
  localparam int XW    = 19;  // CORDIC vector component width
  localparam int ANG_W = 18;  // angle accumulator width, 1/256 units
  localparam int DEG_W = 9;   // whole degrees after wrap
  localparam int TAB_W = 14;  // arctangent table entry width
  localparam int TAB_IW = 5;  // arctangent table index width
  localparam int DUTY_W = 8;
  localparam int PINS_W = 6;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;

  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 18'sd23042;
  localparam logic signed [ANG_W-1:0] ANG_180     = 18'sd46080;

  localparam logic [PINS_W-1:0] PINS_FWD     = 6'h35;
  localparam logic [PINS_W-1:0] PINS_REV     = 6'h2B;
  localparam logic [PINS_W-1:0] PINS_PIVOT_L = 6'h31;
  localparam logic [PINS_W-1:0] PINS_PIVOT_R = 6'h25;
  localparam logic [PINS_W-1:0] PINS_STOP    = 6'h00;

  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_CAP  = 8'd3;

  typedef struct packed {
    logic [7:0] dead_zone;
    logic [2:0] speed_gain;
    logic [2:0] turn_gain;
    logic [7:0] speed_cap;
  } drv_cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] right_duty;
    logic [DUTY_W-1:0] left_duty;
    logic [PINS_W-1:0] drive_pins;
  } drv_res_t;

  // round(57.3*atan(2^-i)*256)
  function automatic logic [TAB_W-1:0] atan_entry(input logic [TAB_IW-1:0] idx);
    logic [TAB_W-1:0] v;
    case (idx)
      5'd0:    v = 14'd11521;
      5'd1:    v = 14'd6801;
      5'd2:    v = 14'd3594;
      5'd3:    v = 14'd1824;
      5'd4:    v = 14'd916;
      5'd5:    v = 14'd458;
      5'd6:    v = 14'd229;
      5'd7:    v = 14'd115;
      5'd8:    v = 14'd57;
      5'd9:    v = 14'd29;
      5'd10:   v = 14'd14;
      5'd11:   v = 14'd7;
      5'd12:   v = 14'd4;
      5'd13:   v = 14'd2;
      5'd14:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> src/tilt_to_differential_drive.sv
// Top level: sample capture, sequencer, configuration and output register
//
// Turns one accelerometer sample (x, y, z) into pitch and roll in whole
// degrees and a two-wheel drive command (right/left duty, driver pins).
// One CORDIC unit is run twice per item, pitch then roll, one rotation per
// cycle; the two angles then feed the drive stage, whose result goes to
// the output register. The next item can be taken once that register is
// loaded. s_tready is high only while the block is idle. The result sits
// in an output register, so the next item is taken while it waits; a
// result still blocked when the next one is ready holds the block until
// the output register frees. Configuration writes are taken in any
// cycle; write them only while no item is in flight. Register indexes:
// 0 dead_zone, 1 speed_gain, 2 turn_gain, 3 speed_cap; other indexes are
// ignored.
`default_nettype none
`include "assert_macros.svh"

module tilt_to_differential_drive #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  input  wire logic [47:0]                        s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // right_duty[7:0], left_duty[15:8], drive_pins[21:16],
  // pitch_deg[30:22], roll_deg[39:31]
  output logic [39:0]                             m_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tdd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tdd_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import tdd_pkg::*;

  typedef enum logic [2:0] {T_IDLE, T_PITCH, T_ROLL, T_DRIVE, T_HOLD} tstate_t;

  tstate_t                 state;
  drv_cfg_t                cfg;
  logic signed [IN_W-1:0]  ax, ay, az;
  logic signed [DEG_W-1:0] pitch, roll;
  logic                    cor_start, drv_start;

  logic signed [NEG_W-1:0] cor_x, cor_y;
  logic                    cor_done;
  logic signed [DEG_W-1:0] cor_deg;
  logic                    drv_done;
  drv_res_t                drv_res;
  logic                    out_free;
  logic                    out_load;

  assign s_tready  = (state == T_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = ((state == T_DRIVE && drv_done) || state == T_HOLD) && out_free;

  // pitch uses (-z, -y), roll uses (-z, -x)
  assign cor_x = -NEG_W'(az);
  assign cor_y = (state == T_PITCH) ? -NEG_W'(ay) : -NEG_W'(ax);

  tdd_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(cor_start),
    .xd   (cor_x),
    .yn   (cor_y),
    .done (cor_done),
    .deg  (cor_deg)
  );

  tdd_drive u_drive (
    .clk  (clk),
    .rst  (rst),
    .start(drv_start),
    .pitch(pitch),
    .roll (roll),
    .cfg  (cfg),
    .done (drv_done),
    .res  (drv_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_zone  <= 8'd30;
      cfg.speed_gain <= 3'd3;
      cfg.turn_gain  <= 3'd2;
      cfg.speed_cap  <= 8'd250;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEAD_ZONE:  cfg.dead_zone  <= cfg_data;
        REG_SPEED_GAIN: cfg.speed_gain <= cfg_data[2:0];
        REG_TURN_GAIN:  cfg.turn_gain  <= cfg_data[2:0];
        REG_SPEED_CAP:  cfg.speed_cap  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      cor_start <= 1'b0;
      drv_start <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      cor_start <= 1'b0;
      drv_start <= 1'b0;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (s_tvalid) begin
            ax        <= s_tdata[15:0];
            ay        <= s_tdata[31:16];
            az        <= s_tdata[47:32];
            cor_start <= 1'b1;
            state     <= T_PITCH;
          end
        end
        T_PITCH: begin
          if (cor_done) begin
            pitch     <= cor_deg;
            cor_start <= 1'b1;
            state     <= T_ROLL;
          end
        end
        T_ROLL: begin
          if (cor_done) begin
            roll      <= cor_deg;
            drv_start <= 1'b1;
            state     <= T_DRIVE;
          end
        end
        T_DRIVE, T_HOLD: begin
          if (out_load) begin
            m_tdata <= {roll, pitch, drv_res.drive_pins,
                        drv_res.left_duty, drv_res.right_duty};
            state   <= T_IDLE;
          end else if (drv_done || state == T_HOLD) begin
            state <= T_HOLD;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_cor_owner, clk, rst, cor_done |-> (state == T_PITCH || state == T_ROLL), "CORDIC finished outside an angle phase")
  `ASSERT_CLK(a_drv_owner, clk, rst, drv_done |-> (state == T_DRIVE), "drive stage finished outside drive phase")

endmodule

`default_nettype wire

>>> src/tdd_cordic.sv
// Shared vectoring CORDIC: one atan2 to whole wrapped degrees per start
`default_nettype none
`include "assert_macros.svh"

module tdd_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [tdd_pkg::NEG_W-1:0]  xd,
  input  wire logic signed [tdd_pkg::NEG_W-1:0]  yn,
  output logic                                   done,
  output logic signed [tdd_pkg::DEG_W-1:0]       deg
);
  import tdd_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS + 1);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

  cstate_t                 state;
  logic [CW-1:0]           cnt;
  logic signed [XW-1:0]    x;
  logic signed [XW-1:0]    y;
  logic signed [ANG_W-1:0] ang;

  logic signed [XW-1:0]    xd_e, yn_e;
  logic signed [XW-1:0]    x_next, y_next, xs, ys;
  logic signed [ANG_W-1:0] ang_next;
  logic signed [ANG_W-1:0] tab_s;
  logic signed [ANG_W-1:0] t_sum;
  logic signed [ANG_W-1:0] t_neg;
  logic signed [DEG_W:0]   d_raw;
  logic signed [DEG_W:0]   d_wrap;

  assign xd_e = XW'(xd);
  assign yn_e = XW'(yn);

  // one rotation step, both updates from the old vector
  always_comb begin
    xs       = x >>> cnt;
    ys       = y >>> cnt;
    tab_s    = $signed({{(ANG_W-TAB_W){1'b0}}, atan_entry(TAB_IW'(cnt))});
    x_next   = x;
    y_next   = y;
    ang_next = ang;
    if (y > 0) begin
      x_next   = x + ys;
      y_next   = y - xs;
      ang_next = ang + tab_s;
    end else if (y < 0) begin
      x_next   = x - ys;
      y_next   = y + xs;
      ang_next = ang - tab_s;
    end
  end

  // offset by 180, truncate toward zero, wrap above 180
  always_comb begin
    t_sum = ang + ANG_180;
    t_neg = -t_sum;
    if (t_sum >= 0) begin
      d_raw = (DEG_W+1)'(t_sum >>> 8);
    end else begin
      d_raw = -((DEG_W+1)'(t_neg >>> 8));
    end
    d_wrap = d_raw;
    if (d_raw > 10'sd180) begin
      d_wrap = d_raw - 10'sd360;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            cnt   <= '0;
            state <= C_RUN;
            // turn a left-half vector by 90 degrees first
            if (xd_e < 0) begin
              if (yn_e >= 0) begin
                x   <= yn_e;
                y   <= -xd_e;
                ang <= ANG_HALF_PI;
              end else begin
                x   <= -yn_e;
                y   <= xd_e;
                ang <= -ANG_HALF_PI;
              end
            end else begin
              x   <= xd_e;
              y   <= yn_e;
              ang <= '0;
            end
          end
        end
        C_RUN: begin
          if (cnt == CW'(CORDIC_STEPS)) begin
            state <= C_FIN;
          end else begin
            x   <= x_next;
            y   <= y_next;
            ang <= ang_next;
            cnt <= cnt + 1'b1;
          end
        end
        C_FIN: begin
          deg   <= DEG_W'(d_wrap);
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_cnt_bound, clk, rst, (state == C_RUN) |-> (cnt <= CW'(CORDIC_STEPS)), "CORDIC step count overran")

endmodule

`default_nettype wire

>>> src/tdd_drive.sv
// Drive rule: dead zone, gains, cap, saturation and held duties
`default_nettype none
`include "assert_macros.svh"

module tdd_drive (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic signed [tdd_pkg::DEG_W-1:0] pitch,
  input  wire logic signed [tdd_pkg::DEG_W-1:0] roll,
  input  wire tdd_pkg::drv_cfg_t                cfg,
  output logic                                  done,
  output tdd_pkg::drv_res_t                     res
);
  import tdd_pkg::*;

  logic signed [9:0]  dz_s;
  logic signed [9:0]  pitch_e, roll_e;
  logic [8:0]         pitch_abs;
  logic signed [12:0] tg_s, roll_s, turn_p;

  logic               go1;
  logic               mov1, fwd1, rhi1, rlo1;
  logic [11:0]        base1;
  logic signed [12:0] turn1;

  logic [DUTY_W-1:0]  held_right, held_left;
  logic [PINS_W-1:0]  pins_out;

  logic signed [13:0] base_s, cap_s, capped, r_val, l_val;
  logic [DUTY_W-1:0]  r_sat, l_sat;
  logic [PINS_W-1:0]  pins_sel;

  assign dz_s      = $signed({2'b00, cfg.dead_zone});
  assign pitch_e   = 10'(pitch);
  assign roll_e    = 10'(roll);
  assign pitch_abs = (pitch < 0) ? 9'(-pitch_e) : 9'(pitch_e);
  assign tg_s      = $signed({10'b0, cfg.turn_gain});
  assign roll_s    = 13'(roll);
  assign turn_p    = tg_s * roll_s;

  function automatic logic [DUTY_W-1:0] sat8(input logic signed [13:0] v);
    logic [DUTY_W-1:0] o;
    if (v < 0) begin
      o = '0;
    end else if (v > 14'sd255) begin
      o = '1;
    end else begin
      o = DUTY_W'(v);
    end
    return o;
  endfunction

  always_comb begin
    base_s = $signed({2'b00, base1});
    cap_s  = $signed({6'b0, cfg.speed_cap});
    capped = (base_s > cap_s) ? cap_s : base_s;
    r_val  = base_s;
    l_val  = base_s;
    if (rhi1) begin
      r_val = base_s - 14'(turn1);
      l_val = capped;
    end else if (rlo1) begin
      r_val = capped;
      l_val = base_s + 14'(turn1);
    end
    r_sat = sat8(r_val);
    l_sat = sat8(l_val);
    if (mov1) begin
      pins_sel = fwd1 ? PINS_FWD : PINS_REV;
    end else if (rlo1) begin
      pins_sel = PINS_PIVOT_L;
    end else if (rhi1) begin
      pins_sel = PINS_PIVOT_R;
    end else begin
      pins_sel = PINS_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      go1        <= 1'b0;
      done       <= 1'b0;
      held_right <= '0;
      held_left  <= '0;
    end else begin
      go1  <= start;
      done <= go1;
      // products and axis tests
      if (start) begin
        mov1  <= (pitch_e > dz_s) || (pitch_e < -dz_s);
        fwd1  <= pitch_e > dz_s;
        rhi1  <= roll_e > dz_s;
        rlo1  <= roll_e < -dz_s;
        base1 <= 12'(cfg.speed_gain) * 12'(pitch_abs);
        turn1 <= turn_p;
      end
      // mix, saturate; pivot and stop hold the duties
      if (go1) begin
        if (mov1) begin
          held_right <= r_sat;
          held_left  <= l_sat;
        end
        pins_out <= pins_sel;
      end
    end
  end

  assign res.right_duty = held_right;
  assign res.left_duty  = held_left;
  assign res.drive_pins = pins_out;

  `ASSERT_CLK(a_hold_duty, clk, rst, go1 && !mov1 |=> $stable(held_right) && $stable(held_left), "duties changed in pivot or stop")

endmodule

`default_nettype wire

>>> sim/tilt_to_differential_drive_tb.sv
`timescale 1ns / 100ps
// Self-checking bench: tilt angles and drive commands against an internal predictor
module tilt_to_differential_drive_tb;
  import tdd_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 2 * CORDIC_STEPS + 20;
  localparam int PHASE_ITEMS  = 150;
  localparam int N_PHASES     = 9;

  // right_duty in the lowest bits, same layout as m_tdata
  typedef struct packed {
    logic signed [DEG_W-1:0] roll_deg;
    logic signed [DEG_W-1:0] pitch_deg;
    logic [PINS_W-1:0]       drive_pins;
    logic [DUTY_W-1:0]       left_duty;
    logic [DUTY_W-1:0]       right_duty;
  } drive_cmd_t;

  class tilt_drive_tracker;
    int dead_zone, speed_gain, turn_gain, speed_cap;
    int held_right, held_left;
    drive_cmd_t pending_cmds[$];
    int unsigned mismatches, orphans, checked;
    int unsigned n_fwd, n_rev, n_pivot, n_stop;

    function new();
      dead_zone  = 30;
      speed_gain = 3;
      turn_gain  = 2;
      speed_cap  = 250;
      held_right = 0;
      held_left  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        REG_DEAD_ZONE:  dead_zone  = val;
        REG_SPEED_GAIN: speed_gain = val[2:0];
        REG_TURN_GAIN:  turn_gain  = val[2:0];
        REG_SPEED_CAP:  speed_cap  = val;
        default: ;
      endcase
    endfunction

    // atan2(num, den) in whole degrees, offset by 180 and wrapped
    function int tilt_degrees(int num, int den);
      int atan_steps [16] = '{11521, 6801, 3594, 1824, 916, 458, 229, 115,
                              57, 29, 14, 7, 4, 2, 1, 0};
      int xv, yv, ang, xs, ys, t, deg;
      xv  = den;
      yv  = num;
      ang = 0;
      // pre-rotate by a quarter turn into the right half plane
      if (xv < 0) begin
        t = xv;
        if (yv >= 0) begin
          xv  = yv;
          yv  = -t;
          ang = int'(ANG_HALF_PI);
        end else begin
          xv  = -yv;
          yv  = t;
          ang = -int'(ANG_HALF_PI);
        end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = xv >>> i;
        ys = yv >>> i;
        if (yv > 0) begin
          xv  = xv + ys;
          yv  = yv - xs;
          ang = ang + atan_steps[i];
        end else if (yv < 0) begin
          xv  = xv - ys;
          yv  = yv + xs;
          ang = ang - atan_steps[i];
        end
      end
      t   = ang + int'(ANG_180);
      deg = (t >= 0) ? (t >>> 8) : -((-t) >>> 8);
      if (deg > 180) deg = deg - 360;
      return deg;
    endfunction

    function int sat_duty(int v);
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
    endfunction

    function void note_sample(logic [47:0] sample);
      int ax, ay, az, pitch, roll, base, r, l;
      drive_cmd_t cmd;
      ax    = $signed(sample[15:0]);
      ay    = $signed(sample[31:16]);
      az    = $signed(sample[47:32]);
      pitch = tilt_degrees(-ay, -az);
      roll  = tilt_degrees(-ax, -az);
      if (pitch > dead_zone || pitch < -dead_zone) begin
        base = (pitch > dead_zone) ? speed_gain * pitch : -speed_gain * pitch;
        cmd.drive_pins = (pitch > dead_zone) ? PINS_FWD : PINS_REV;
        if (roll > dead_zone) begin
          r = base - turn_gain * roll;
          l = (base > speed_cap) ? speed_cap : base;
        end else if (roll < -dead_zone) begin
          r = (base > speed_cap) ? speed_cap : base;
          l = base + turn_gain * roll;
        end else begin
          r = base;
          l = base;
        end
        held_right = sat_duty(r);
        held_left  = sat_duty(l);
        if (pitch > dead_zone) n_fwd++;
        else n_rev++;
      end else if (roll < -dead_zone) begin
        cmd.drive_pins = PINS_PIVOT_L;
        n_pivot++;
      end else if (roll > dead_zone) begin
        cmd.drive_pins = PINS_PIVOT_R;
        n_pivot++;
      end else begin
        cmd.drive_pins = PINS_STOP;
        n_stop++;
      end
      cmd.right_duty = held_right[DUTY_W-1:0];
      cmd.left_duty  = held_left[DUTY_W-1:0];
      cmd.pitch_deg  = pitch[DEG_W-1:0];
      cmd.roll_deg   = roll[DEG_W-1:0];
      pending_cmds.push_back(cmd);
    endfunction

    function void check_command(drive_cmd_t got);
      drive_cmd_t want;
      if (pending_cmds.size() == 0) begin
        orphans++;
        if (orphans <= 10)
          $display("unexpected result: R%0d L%0d pins %h pitch %0d roll %0d",
                   got.right_duty, got.left_duty, got.drive_pins, got.pitch_deg,
                   got.roll_deg);
        return;
      end
      want = pending_cmds.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want R%0d L%0d pins %h pitch %0d roll %0d, got R%0d L%0d pins %h pitch %0d roll %0d",
                   want.right_duty, want.left_duty, want.drive_pins, want.pitch_deg,
                   want.roll_deg, got.right_duty, got.left_duty, got.drive_pins,
                   got.pitch_deg, got.roll_deg);
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [47:0]          s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [39:0]          m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  bit          steady = 1'b0;
  int          stall_left = 0;
  int unsigned n_items = 0;
  int unsigned n_writes = 0;
  tilt_drive_tracker tracker = new();

  tilt_to_differential_drive #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver stalls: mostly short, now and then much longer
  always @(posedge clk) begin
    if (steady) begin
      stall_left <= 0;
      m_tready   <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if ($urandom_range(999) < 25) begin
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(90, 40) : $urandom_range(5, 1);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_command(drive_cmd_t'(m_tdata));
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_sample(input logic [47:0] sample);
    int gap;
    gap = (!steady && $urandom_range(99) < 18) ? $urandom_range(50, 1) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_sample(sample);
    n_items++;
  endtask

  // Drop valid and wait for every pending command
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending_cmds.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, val);
    n_writes++;
  endtask

  task automatic apply_settings(input int dz, input int sg, input int tg, input int cap,
                                input bit junk);
    logic [4:0] hi_sg, hi_tg;
    hi_sg = junk ? 5'($urandom) : 5'd0;
    hi_tg = junk ? 5'($urandom) : 5'd0;
    hold_until_drained();
    write_reg(REG_DEAD_ZONE, 8'(dz));
    write_reg(REG_SPEED_GAIN, {hi_sg, 3'(sg)});
    write_reg(REG_TURN_GAIN, {hi_tg, 3'(tg)});
    write_reg(REG_SPEED_CAP, 8'(cap));
    // unmapped index must leave every setting alone
    write_reg(CFG_IDX_W'($urandom_range(255, 4)), 8'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] corner_value();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0001;
      default: return 16'h0000;
    endcase
  endfunction

  // Mostly plausible gravity vectors, the rest corners and raw noise
  function automatic logic [47:0] random_sample();
    int kind, zmag, span, x, y, z;
    kind = $urandom_range(99);
    if (kind < 20) return 48'({$urandom(), $urandom()});
    if (kind < 30) return {corner_value(), corner_value(), corner_value()};
    zmag = $urandom_range(20000, 1000);
    span = zmag + zmag / 2;
    x = int'($urandom_range(2 * span)) - span;
    y = int'($urandom_range(2 * span)) - span;
    z = ($urandom_range(99) < 80) ? zmag : -zmag;
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  initial begin : stimulus
    logic [47:0] corner_cases[$];
    int axis_pts [3] = '{-16384, 0, 16384};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // level, tilted and turning cases on a 3x3 grid, then field extremes
    foreach (axis_pts[i])
      foreach (axis_pts[j])
        corner_cases.push_back({16'sd16384, 16'(axis_pts[j]), 16'(axis_pts[i])});
    corner_cases.push_back({16'h0000, 16'h0000, 16'h0000});
    corner_cases.push_back({16'h8000, 16'h8000, 16'h8000});
    corner_cases.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF});
    corner_cases.push_back({16'h0000, 16'h7FFF, 16'h8000});
    corner_cases.push_back({16'h0000, 16'h8000, 16'h7FFF});
    corner_cases.push_back({16'h8000, 16'h0000, 16'h0000});
    corner_cases.push_back({16'h7FFF, 16'h0000, 16'h0000});
    corner_cases.push_back({16'hFFFF, 16'h0000, 16'h0000});
    corner_cases.push_back({16'h0001, 16'hFFFF, 16'h0001});
    corner_cases.push_back({16'h7FFF, 16'h8000, 16'h8000});
    corner_cases.push_back({16'h8000, 16'h7FFF, 16'h7FFF});
    corner_cases.push_back({16'sd16384, 16'sd8000, 16'sd0});
    foreach (corner_cases[k]) send_sample(corner_cases[k]);

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        1: apply_settings(0, 7, 7, 255, 1'b0);
        2: apply_settings(180, 0, 0, 0, 1'b0);
        3: apply_settings(255, 7, 7, 0, 1'b0);
        4: apply_settings(10, 1, 7, 100, 1'b0);
        5: apply_settings(5, 7, 1, 255, 1'b0);
        6: apply_settings(45, 4, 3, 200, 1'b0);
        7, 8: apply_settings($urandom_range(60), $urandom_range(7), $urandom_range(7),
                             $urandom_range(255), 1'b1);
        default: ;
      endcase
      steady = (p == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) hold_until_drained();
        send_sample(random_sample());
      end
    end
    steady = 1'b0;

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d samples over %0d register writes, %0d results checked",
             n_items, n_writes, tracker.checked);
    $display("Drive modes: %0d forward, %0d reverse, %0d pivot, %0d stop; %0d mismatches, %0d unexpected",
             tracker.n_fwd, tracker.n_rev, tracker.n_pivot, tracker.n_stop,
             tracker.mismatches, tracker.orphans);
    if (tracker.mismatches == 0 && tracker.orphans == 0 && tracker.pending_cmds.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
